>>> hdl/dad_pkg.sv
`timescale 1ns / 1ps

package dad_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_CLASSES    = 3'd0,
    REG_NUM_MASKS      = 3'd1,
    REG_INPUT_WIDTH    = 3'd2,
    REG_INPUT_HEIGHT   = 3'd3,
    REG_CONF_THRESHOLD = 3'd4
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  // Reset values of the configuration registers
  localparam logic [8:0]  RstNumClasses   = 9'd80;
  localparam logic [6:0]  RstNumMasks     = 7'd32;
  localparam logic [12:0] RstInputWidth   = 13'd640;
  localparam logic [12:0] RstInputHeight  = 13'd640;
  localparam logic [16:0] RstConfThresh   = 17'd16384;

  localparam logic [12:0] MaxInputSize    = 13'd4096;
  localparam logic [16:0] NormOne         = 17'd65536;

  // Job queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [8:0]  num_classes;
    logic [6:0]  num_masks;
    logic [12:0] input_width;
    logic [12:0] input_height;
    logic [16:0] conf_threshold;
  } cfg_t;

  // One detection that passed the threshold, waiting for box math
  typedef struct packed {
    logic [13:0]        anchor;
    logic [7:0]         label;
    logic signed [31:0] score;
    logic signed [31:0] raw_x;
    logic signed [31:0] raw_y;
    logic signed [31:0] raw_w;
    logic signed [31:0] raw_h;
  } job_t;

endpackage

>>> hdl/detection_anchor_decoder.sv
`timescale 1ns / 1ps

// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | push_i / full_o           | value_i, frame_start_i
// result    | pop_i / empty_o           | anchor_index_o, label_o, score_o, box_*_o
// config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front takes one row element per cycle while the job queue has room.
// Each passing anchor occupies the back divider: it takes the request, computes
// four quotients, each by load, check and a restoring division, and hands the
// result to the output register; the two-entry job queue and the output
// register absorb this, then full_o stalls the input.
// Reset clears counters and control; no clearing pass is needed.
// Configuration writes are always ready.
module detection_anchor_decoder #(
  parameter int unsigned MAX_CLASSES = 256,
  parameter int unsigned MAX_MASKS   = 64,
  parameter int unsigned MAX_ANCHORS = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [31:0]                   value_i,
  input  logic                          frame_start_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [13:0]                   anchor_index_o,
  output logic [7:0]                    label_o,
  output logic [31:0]                   score_o,
  output logic [16:0]                   box_x_o,
  output logic [16:0]                   box_y_o,
  output logic [16:0]                   box_w_o,
  output logic [16:0]                   box_h_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dad_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dad_pkg::CfgDataW-1:0]  cfg_data_i
);

  dad_pkg::cfg_t      cfg_q;
  dad_pkg::job_t      job_in, job_out;
  logic               job_push, job_pop, job_full, job_empty;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !job_full;
  assign full_o      = job_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_classes    <= dad_pkg::RstNumClasses;
      cfg_q.num_masks      <= dad_pkg::RstNumMasks;
      cfg_q.input_width    <= dad_pkg::RstInputWidth;
      cfg_q.input_height   <= dad_pkg::RstInputHeight;
      cfg_q.conf_threshold <= dad_pkg::RstConfThresh;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dad_pkg::REG_NUM_CLASSES:    cfg_q.num_classes    <= cfg_data_i[8:0];
        dad_pkg::REG_NUM_MASKS:      cfg_q.num_masks      <= cfg_data_i[6:0];
        dad_pkg::REG_INPUT_WIDTH:    cfg_q.input_width    <= cfg_data_i[12:0];
        dad_pkg::REG_INPUT_HEIGHT:   cfg_q.input_height   <= cfg_data_i[12:0];
        dad_pkg::REG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dad_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_MASKS   (MAX_MASKS),
    .MAX_ANCHORS (MAX_ANCHORS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .value_i       (value_i),
    .frame_start_i (frame_start_i),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  dad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  dad_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .anchor_index_o (anchor_index_o),
    .label_o        (label_o),
    .score_o        (score_o),
    .box_x_o        (box_x_o),
    .box_y_o        (box_y_o),
    .box_w_o        (box_w_o),
    .box_h_o        (box_h_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("detection pushed into a full job queue");
`endif

endmodule

>>> hdl/dad_queue.sv
`timescale 1ns / 1ps

module dad_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dad_pkg::job_t wdata_i,
  input  logic          pop_i,
  output dad_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (dad_pkg::QueueDepth > 1) ? $clog2(dad_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(dad_pkg::QueueDepth + 1);

  dad_pkg::job_t       slot_q [dad_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(dad_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  // storage, no reset on payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(dad_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(dad_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(dad_pkg::QueueDepth))
    else $error("job queue count above depth");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("job queue lost a request");
`endif

endmodule

>>> hdl/dad_front.sv
`timescale 1ns / 1ps

module dad_front #(
  parameter int unsigned MAX_CLASSES = 256,
  parameter int unsigned MAX_MASKS   = 64,
  parameter int unsigned MAX_ANCHORS = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dad_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [31:0]   value_i,
  input  logic          frame_start_i,
  output logic          job_push_o,
  output dad_pkg::job_t job_o
);

  localparam int unsigned RW  = $clog2(4 + MAX_CLASSES + MAX_MASKS + 1);
  localparam int unsigned NW  = (RW > 9) ? RW : 9;
  localparam int unsigned CW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned AW  = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

  logic [RW-1:0]      row_pos_q, row_pos_d;
  logic [AW-1:0]      anchor_q, anchor_d;
  logic signed [31:0] best_q, best_d;
  logic [CW-1:0]      class_q, class_d;
  logic [31:0]        box_q [4];

  logic [NW-1:0]      nc_ext, nm_ext, nc_lim, nm_lim;
  logic [RW-1:0]      nc_eff, nm_eff, last_pos, pos;
  logic [AW-1:0]      anchor_base;
  logic [CW-1:0]      k;
  logic               is_box, is_class, is_last, passes;
  logic [AW+13:0]     anchor_ext;
  logic [CW+7:0]      class_ext;

  // effective row geometry
  always_comb begin
    nc_ext = NW'(cfg_i.num_classes);
    nm_ext = NW'(cfg_i.num_masks);
    if (nc_ext == '0) begin
      nc_lim = NW'(1);
    end else if (nc_ext > NW'(MAX_CLASSES)) begin
      nc_lim = NW'(MAX_CLASSES);
    end else begin
      nc_lim = nc_ext;
    end
    nm_lim   = (nm_ext > NW'(MAX_MASKS)) ? NW'(MAX_MASKS) : nm_ext;
    nc_eff   = nc_lim[RW-1:0];
    nm_eff   = nm_lim[RW-1:0];
    last_pos = RW'(3) + nc_eff + nm_eff;
  end

  // per-element classification and running argmax
  always_comb begin
    pos         = frame_start_i ? '0 : row_pos_q;
    anchor_base = frame_start_i ? '0 : anchor_q;
    is_box      = (pos < RW'(4));
    is_class    = !is_box && (pos < RW'(4) + nc_eff);
    is_last     = (pos >= last_pos);
    k           = CW'(pos - RW'(4));
    best_d      = best_q;
    class_d     = class_q;
    if (is_class && ((k == '0) || ($signed(value_i) > best_q))) begin
      best_d  = $signed(value_i);
      class_d = k;
    end
    passes = ($signed({best_d[31], best_d}) >= $signed({16'b0, cfg_i.conf_threshold}));
    if (is_last) begin
      row_pos_d = '0;
      anchor_d  = (anchor_base == AW'(MAX_ANCHORS - 1)) ? '0 : anchor_base + 1'b1;
    end else begin
      row_pos_d = pos + 1'b1;
      anchor_d  = anchor_base;
    end
    anchor_ext = (AW + 14)'(anchor_base);
    class_ext  = (CW + 8)'(class_d);
  end

  assign job_push_o   = accept_i && is_last && passes;
  assign job_o.anchor = anchor_ext[13:0];
  assign job_o.label  = class_ext[7:0];
  assign job_o.score  = best_d;
  assign job_o.raw_x  = $signed(box_q[0]);
  assign job_o.raw_y  = $signed(box_q[1]);
  assign job_o.raw_w  = $signed(box_q[2]);
  assign job_o.raw_h  = $signed(box_q[3]);

  // raw box capture
  always_ff @(posedge clk_i) begin
    if (accept_i && is_box) begin
      box_q[pos[1:0]] <= value_i;
    end
  end

  // counters and argmax state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      anchor_q  <= '0;
      best_q    <= '0;
      class_q   <= '0;
    end else if (accept_i) begin
      row_pos_q <= row_pos_d;
      anchor_q  <= anchor_d;
      best_q    <= best_d;
      class_q   <= class_d;
    end
  end

endmodule

>>> hdl/dad_back.sv
`timescale 1ns / 1ps

module dad_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dad_pkg::cfg_t cfg_i,
  input  logic          job_empty_i,
  input  dad_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [13:0]   anchor_index_o,
  output logic [7:0]    label_o,
  output logic [31:0]   score_o,
  output logic [16:0]   box_x_o,
  output logic [16:0]   box_y_o,
  output logic [16:0]   box_w_o,
  output logic [16:0]   box_h_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_CHECK,
    S_ITER,
    S_DONE
  } state_e;

  state_e             state_q;
  dad_pkg::job_t      job_q;
  logic [1:0]         sel_q;
  logic [4:0]         bit_q;
  logic signed [35:0] t_q;
  logic [13:0]        div_q;
  logic [13:0]        rem_q;
  logic [17:0]        shf_q;
  logic [17:0]        quo_q;
  logic [16:0]        res_q [4];
  logic               out_valid_q;
  logic [13:0]        out_anchor_q;
  logic [7:0]         out_label_q;
  logic [31:0]        out_score_q;
  logic [16:0]        out_box_q [4];

  logic [12:0]        wd, ht, dsel;
  logic signed [35:0] xe, ye, we, he, num;
  logic [14:0]        rem_sh;
  logic               ge;
  logic [16:0]        quo_clamped;
  logic               out_load;

  // clamp input sizes to 1..4096
  always_comb begin
    if (cfg_i.input_width == '0) begin
      wd = 13'd1;
    end else if (cfg_i.input_width > dad_pkg::MaxInputSize) begin
      wd = dad_pkg::MaxInputSize;
    end else begin
      wd = cfg_i.input_width;
    end
    if (cfg_i.input_height == '0) begin
      ht = 13'd1;
    end else if (cfg_i.input_height > dad_pkg::MaxInputSize) begin
      ht = dad_pkg::MaxInputSize;
    end else begin
      ht = cfg_i.input_height;
    end
  end

  // numerator for the current box term
  always_comb begin
    xe = 36'(job_q.raw_x);
    ye = 36'(job_q.raw_y);
    we = 36'(job_q.raw_w);
    he = 36'(job_q.raw_h);
    unique case (sel_q)
      2'd0: num = (xe <<< 1) - we;
      2'd1: num = (ye <<< 1) - he;
      2'd2: num = we <<< 1;
      2'd3: num = he <<< 1;
      default: num = '0;
    endcase
    dsel = sel_q[0] ? ht : wd;
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh      = {rem_q, shf_q[17]};
    ge          = (rem_sh >= {1'b0, div_q});
    quo_clamped = (quo_q > 18'(dad_pkg::NormOne)) ? dad_pkg::NormOne : quo_q[16:0];
  end

  assign out_load       = (state_q == S_DONE) && (!out_valid_q || pop_i);
  assign job_pop_o      = (state_q == S_IDLE) && !job_empty_i;
  assign empty_o        = !out_valid_q;
  assign anchor_index_o = out_anchor_q;
  assign label_o        = out_label_q;
  assign score_o        = out_score_q;
  assign box_x_o        = out_box_q[0];
  assign box_y_o        = out_box_q[1];
  assign box_w_o        = out_box_q[2];
  assign box_h_o        = out_box_q[3];

  // sequencer, divider and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sel_q       <= '0;
      bit_q       <= '0;
    end else begin
      // output slot: a finished request replaces a popped or empty one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            sel_q   <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          // rounding offset: (n + d) / 2d
          t_q     <= num + $signed({23'b0, dsel});
          div_q   <= {dsel, 1'b0};
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (t_q[35]) begin
            res_q[sel_q] <= '0;
            sel_q        <= sel_q + 1'b1;
            state_q      <= (sel_q == 2'd3) ? S_DONE : S_LOAD;
          end else if (t_q[34:0] >= 35'({div_q, 18'b0})) begin
            res_q[sel_q] <= dad_pkg::NormOne;
            sel_q        <= sel_q + 1'b1;
            state_q      <= (sel_q == 2'd3) ? S_DONE : S_LOAD;
          end else begin
            rem_q   <= t_q[31:18];
            shf_q   <= t_q[17:0];
            quo_q   <= '0;
            bit_q   <= '0;
            state_q <= S_ITER;
          end
        end
        S_ITER: begin
          rem_q <= ge ? 14'(rem_sh - {1'b0, div_q}) : rem_sh[13:0];
          shf_q <= {shf_q[16:0], 1'b0};
          quo_q <= {quo_q[16:0], ge};
          bit_q <= bit_q + 1'b1;
          if (bit_q == 5'd18) begin
            res_q[sel_q] <= quo_clamped;
            sel_q        <= sel_q + 1'b1;
            state_q      <= (sel_q == 2'd3) ? S_DONE : S_LOAD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_anchor_q <= job_q.anchor;
            out_label_q  <= job_q.label;
            out_score_q  <= job_q.score;
            out_box_q[0] <= res_q[0];
            out_box_q[1] <= res_q[1];
            out_box_q[2] <= res_q[2];
            out_box_q[3] <= res_q[3];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER) |-> (bit_q <= 5'd18))
    else $error("divider ran past its quotient width");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");
`endif

endmodule
